// File: design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion checked only outside reset.
`define TRL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion checked at every clock edge, reset included.
`define TRL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/trl_pkg.sv
// Types and constants shared by the target rate limiter modules.
`timescale 1ns / 1ps

package trl_pkg;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic [7:0]  hash;
    logic [31:0] now_seconds;
    logic        immune;
  } trl_item_t;

  // One result as it leaves the back.
  typedef struct packed {
    logic        refused;
    logic [31:0] wait_seconds;
    logic [1:0]  lag_add;
    logic        was_known;
  } trl_result_t;

  // Sequencer of the back part.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EVAL,
    BK_COMMIT
  } trl_back_state_t;

  // Register indexes on the configuration port.
  localparam logic REG_LIST_LENGTH = 1'b0;
  localparam logic REG_INTERVAL    = 1'b1;

  localparam logic [5:0]  LIST_LENGTH_RESET = 6'd20;
  localparam logic [15:0] INTERVAL_RESET    = 16'd15;

  localparam int QDEPTH = 2;

  // Bounds of the 40-bit signed next-allowed time, widened for arithmetic.
  localparam logic signed [41:0] NAT_MAX_X = 42'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] NAT_MAX   = 40'sh7F_FFFF_FFFF;
  localparam logic [1:0]         REFUSE_LAG = 2'd2;
  localparam logic signed [41:0] REFUSE_STEP = 42'sd2;

  // Fold a 32-bit target reference to its 8-bit hash.
  function automatic logic [7:0] trl_hash(input logic [31:0] v);
    logic [31:0] f;
    f = (v >> 17) ^ (v >> 9);
    return f[7:0];
  endfunction

endpackage

// File: design/trl_front.sv
// Front part: accepts requests, hashes the target reference, feeds the queue.
`timescale 1ns / 1ps

module trl_front
  import trl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] target_ref,
  input  logic [31:0] now_seconds,
  input  logic        immune,
  output logic        push_valid,
  input  logic        push_ready,
  output trl_item_t   push_item
);

  logic      held;
  trl_item_t item;

  assign in_ready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.hash        <= trl_hash(target_ref);
      item.now_seconds <= now_seconds;
      item.immune      <= immune;
    end
  end

endmodule

// File: design/trl_queue.sv
// Short queue between the front and the back parts.
`timescale 1ns / 1ps

module trl_queue
  import trl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  trl_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output trl_item_t rd_item
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  trl_item_t       slots [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_wr;
  logic            do_rd;

  assign wr_ready = (count != CW'(QDEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// File: design/trl_back.sv
// Back part: searches the recent list, updates the time budget, makes results.
`timescale 1ns / 1ps

module trl_back
  import trl_pkg::*;
#(
  parameter int MAX_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [5:0]  list_length,
  input  logic [15:0] new_target_interval,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  trl_item_t   pop_item,
  output logic        res_valid,
  input  logic        res_ready,
  output trl_result_t res
);

  localparam int LW = $clog2(MAX_SLOTS + 1);
  localparam int KW = LW + 16;

  trl_back_state_t state;
  trl_back_state_t state_next;

  logic [7:0]             recent [MAX_SLOTS];
  logic signed [39:0]     nat;

  logic [LW-1:0]          len_q;
  logic [KW-1:0]          k_len;
  logic signed [KW+1:0]   k_back;
  logic [8:0]             len_raw;
  logic [8:0]             len_clamp;

  trl_item_t              work;
  logic [MAX_SLOTS-1:0]   shift_mask;
  logic [MAX_SLOTS-1:0]   mask_next;
  logic [MAX_SLOTS-1:0]   match;
  logic                   found;
  logic                   early;
  logic                   catch_up;

  logic signed [41:0]     now_x;
  logic signed [41:0]     nat_x;
  logic signed [41:0]     reach;
  logic signed [41:0]     bump;
  logic signed [41:0]     advance;
  logic signed [41:0]     restart;
  logic signed [41:0]     gap;
  logic signed [39:0]     nat_refused;
  logic signed [39:0]     nat_passed;
  logic [31:0]            wait_sat;
  logic                   acc;

  // Effective length and the two catch-up products follow the registers.
  always_comb begin
    len_raw = 9'(list_length);
    if (len_raw == 9'd0) begin
      len_clamp = 9'd1;
    end else if (len_raw > 9'(MAX_SLOTS)) begin
      len_clamp = 9'(MAX_SLOTS);
    end else begin
      len_clamp = len_raw;
    end
  end

  always_ff @(posedge clk) begin
    len_q  <= LW'(len_clamp);
    k_len  <= KW'(len_q) * KW'(new_target_interval);
    k_back <= $signed((KW+2)'(k_len)) - $signed((KW+2)'({new_target_interval, 1'b0}));
  end

  assign now_x = $signed({10'd0, work.now_seconds});
  assign nat_x = 42'(nat);
  assign reach = nat_x + $signed(42'(k_len));

  // Search over the active slots; a slot moves when no match lies before it.
  always_comb begin
    acc = 1'b0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      match[k]     = (recent[k] == work.hash) && (LW'(k) < len_q);
      mask_next[k] = (LW'(k) < len_q) && !acc;
      acc          = acc | match[k];
    end
  end

  // Time arithmetic of the commit step.
  always_comb begin
    bump    = nat_x + REFUSE_STEP;
    advance = nat_x + $signed({26'd0, new_target_interval});
    restart = now_x - 42'(k_back);
    gap     = bump - now_x;
    nat_refused = (bump > NAT_MAX_X) ? NAT_MAX : bump[39:0];
    nat_passed  = catch_up ? restart[39:0]
                : ((advance > NAT_MAX_X) ? NAT_MAX : advance[39:0]);
    if (gap[41:32] != 10'd0) begin
      wait_sat = gap[41] ? 32'd0 : 32'hFFFF_FFFF;
    end else begin
      wait_sat = gap[31:0];
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    case (state)
      BK_IDLE: begin
        pop_ready = !res_valid || res_ready;
        if (pop_valid && pop_ready) begin
          state_next = BK_EVAL;
        end
      end
      BK_EVAL: begin
        state_next = BK_COMMIT;
      end
      BK_COMMIT: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && pop_valid && pop_ready) begin
      work <= pop_item;
    end
    if (state == BK_EVAL) begin
      shift_mask <= mask_next;
      found      <= |match;
      early      <= now_x < nat_x;
      catch_up   <= now_x > reach;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nat       <= '0;
      res_valid <= 1'b0;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        recent[k] <= 8'd0;
      end
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (state == BK_COMMIT) begin
        res_valid <= 1'b1;
        if (!work.immune) begin
          if (!found && early) begin
            nat <= nat_refused;
          end else begin
            if (!found) begin
              nat <= nat_passed;
            end
            for (int k = 1; k < MAX_SLOTS; k++) begin
              if (shift_mask[k]) begin
                recent[k] <= recent[k-1];
              end
            end
            recent[0] <= work.hash;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_COMMIT) begin
      if (work.immune) begin
        res <= '0;
      end else if (found) begin
        res.refused      <= 1'b0;
        res.wait_seconds <= 32'd0;
        res.lag_add      <= 2'd0;
        res.was_known    <= 1'b1;
      end else if (early) begin
        res.refused      <= 1'b1;
        res.wait_seconds <= wait_sat;
        res.lag_add      <= REFUSE_LAG;
        res.was_known    <= 1'b0;
      end else begin
        res <= '0;
      end
    end
  end

endmodule

// File: design/target_rate_limiter_mru_top.sv
// Top level of the recent-target rate limiter with its configuration port.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+---------------------------------------
//   request   | in_valid / in_ready       | target_ref, now_seconds, immune
//   result    | out_valid / out_ready     | refused, wait_seconds, lag_add, was_known
//   config    | psel, penable, pwrite     | paddr, pwdata, prdata (pready tied high)
//
// A request is registered in the front, where its target is hashed, and then
// waits in a two-entry queue. The back handles one request at a time: fetch
// from the queue, search of the recent list, then commit of list, time and
// result. It takes another request only in its idle state and while the result
// register is free or being emptied, so the sustained rate is set by that
// search-then-commit sequence on the shared list and by result stalls.
// Reset is synchronous: it empties the front, the queue and the output register,
// clears the list and the next-allowed time, and loads the register defaults.
// A stalled result holds only the back; the front and queue keep taking
// requests until the queue and the front register are full.
`timescale 1ns / 1ps

module target_rate_limiter_mru_top
  import trl_pkg::*;
#(
  parameter int MAX_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] target_ref,
  input  logic [31:0] now_seconds,
  input  logic        immune,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        refused,
  output logic [31:0] wait_seconds,
  output logic [1:0]  lag_add,
  output logic        was_known,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [5:0]  list_length;
  logic [15:0] new_target_interval;

  logic        push_valid;
  logic        push_ready;
  trl_item_t   push_item;
  logic        pop_valid;
  logic        pop_ready;
  trl_item_t   pop_item;
  trl_result_t res;

  // The register index is the word address; reads are zero-extended to 32 bits.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length         <= LIST_LENGTH_RESET;
      new_target_interval <= INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_LIST_LENGTH) begin
        list_length <= pwdata[5:0];
      end else begin
        new_target_interval <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LIST_LENGTH: prdata = {26'd0, list_length};
      REG_INTERVAL:    prdata = {16'd0, new_target_interval};
      default:         prdata = 32'd0;
    endcase
  end

  trl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .target_ref  (target_ref),
    .now_seconds (now_seconds),
    .immune      (immune),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_item   (push_item)
  );

  trl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  trl_back #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .list_length         (list_length),
    .new_target_interval (new_target_interval),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_item            (pop_item),
    .res_valid           (out_valid),
    .res_ready           (out_ready),
    .res                 (res)
  );

  // Result fields leave straight from the output register of the back.
  assign refused      = res.refused;
  assign wait_seconds = res.wait_seconds;
  assign lag_add      = res.lag_add;
  assign was_known    = res.was_known;

endmodule

// File: design/trl_checker.sv
// Port-level checker for the rate limiter and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trl_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        refused,
  input logic [31:0] wait_seconds,
  input logic [1:0]  lag_add,
  input logic        was_known
);

  `TRL_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result valid after reset")
  `TRL_ASSERT(a_refuse_fields, clk, rst, out_valid && refused |-> lag_add == 2'd2 && !was_known && wait_seconds != 32'd0, "refused result with wrong fields")
  `TRL_ASSERT(a_pass_fields, clk, rst, out_valid && !refused |-> lag_add == 2'd0 && wait_seconds == 32'd0, "passed result charges lag or wait")
  `TRL_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(wait_seconds), "stalled result changed")

endmodule

bind target_rate_limiter_mru_top trl_checker u_trl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .refused      (refused),
  .wait_seconds (wait_seconds),
  .lag_add      (lag_add),
  .was_known    (was_known)
);

// File: bench/tb_target_rate_limiter_mru_top.sv
// Self-checking testbench for the recent-target rate limiter top level.
`timescale 1ns / 1ps

module tb_target_rate_limiter_mru_top;
  import trl_pkg::*;

  // The list depth of the block under test. It matches the default parameter.
  localparam int unsigned LIST_SLOTS = 32;

  // Cycles to let pass after the last expected result before the block is
  // treated as idle.
  localparam int SETTLE = 8;

  // Bounds of the signed 40-bit next-allowed time.
  localparam longint TIME_MAX = 64'sd549755813887;
  localparam longint TIME_MIN = -TIME_MAX - 1;
  localparam longint WAIT_MAX = 64'sd4294967295;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] target_ref;
  logic [31:0] now_seconds;
  logic        immune;
  logic        out_valid;
  logic        out_ready;
  logic        refused;
  logic [31:0] wait_seconds;
  logic [1:0]  lag_add;
  logic        was_known;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  target_rate_limiter_mru_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .target_ref   (target_ref),
    .now_seconds  (now_seconds),
    .immune       (immune),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .refused      (refused),
    .wait_seconds (wait_seconds),
    .lag_add      (lag_add),
    .was_known    (was_known),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Shadow copy of the block's state and registers. It advances once for every
  // request transfer, in transfer order.
  logic [7:0]  recent_hashes_shadow [LIST_SLOTS];
  longint      next_allowed_shadow;
  logic [5:0]  list_len_cfg;
  logic [15:0] interval_cfg;

  // Results still owed by the block, oldest first.
  trl_result_t expected_results [$];

  // When set, neither the sender nor the receiver inserts idle cycles.
  bit quiet_phase;
  int ready_hold;

  int mismatch_count;
  int requests_sent;
  int results_checked;
  int known_count;
  int refused_count;
  int immune_count;
  int catchup_count;
  int settings_written;
  int drain_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Number of slots the block searches: zero counts as one, and anything past
  // the list depth counts as the full depth.
  function automatic int unsigned active_slots();
    if (list_len_cfg == 6'd0)
      return 1;
    if (list_len_cfg > LIST_SLOTS)
      return LIST_SLOTS;
    return list_len_cfg;
  endfunction

  function automatic longint clamp_time(input longint x);
    if (x > TIME_MAX)
      return TIME_MAX;
    if (x < TIME_MIN)
      return TIME_MIN;
    return x;
  endfunction

  // A target reference that folds to hash h, with every other bit random.
  function automatic logic [31:0] ref_for_hash(input logic [7:0] h);
    logic [7:0] r;
    r = 8'($urandom);
    return {7'($urandom), r, h ^ r, 9'($urandom)};
  endfunction

  function automatic void reset_shadow();
    int k;
    for (k = 0; k < LIST_SLOTS; k++)
      recent_hashes_shadow[k] = 8'd0;
    next_allowed_shadow = 0;
    list_len_cfg = LIST_LENGTH_RESET;
    interval_cfg = INTERVAL_RESET;
  endfunction

  // Applies one request to the shadow state and returns the result it earns.
  function automatic trl_result_t apply_request(input logic [31:0] target_v,
                                                input logic [31:0] now_v,
                                                input logic imm);
    trl_result_t r;
    logic [31:0] folded;
    logic [7:0]  h;
    int unsigned len;
    longint      ivl;
    longint      now_l;
    longint      diff;
    int          pos;
    int          k;
    r = '0;
    if (imm) begin
      immune_count++;
      return r;
    end
    folded = (target_v >> 17) ^ (target_v >> 9);
    h = folded[7:0];
    len = active_slots();
    ivl = longint'(interval_cfg);
    now_l = {32'd0, now_v};
    pos = -1;
    for (k = 0; k < len; k++)
      if (pos < 0 && recent_hashes_shadow[k] == h)
        pos = k;
    if (pos >= 0) begin
      // Known target: move it to the front and let it through.
      for (k = pos; k > 0; k--)
        recent_hashes_shadow[k] = recent_hashes_shadow[k - 1];
      recent_hashes_shadow[0] = h;
      r.was_known = 1'b1;
      known_count++;
      return r;
    end
    if (now_l < next_allowed_shadow) begin
      // New target too early: refuse it and push the next-allowed time out.
      next_allowed_shadow = clamp_time(next_allowed_shadow + 2);
      diff = next_allowed_shadow - now_l;
      if (diff > WAIT_MAX)
        diff = WAIT_MAX;
      if (diff < 0)
        diff = 0;
      r.refused = 1'b1;
      r.wait_seconds = diff[31:0];
      r.lag_add = REFUSE_LAG;
      refused_count++;
      return r;
    end
    // A next-allowed time that lies far in the past is pulled up first, so idle
    // credit never grows beyond one full list of new targets.
    if (now_l > next_allowed_shadow + longint'(len) * ivl) begin
      next_allowed_shadow = clamp_time(now_l - longint'(len - 1) * ivl);
      catchup_count++;
    end
    next_allowed_shadow = clamp_time(next_allowed_shadow + ivl);
    for (k = len - 1; k > 0; k--)
      recent_hashes_shadow[k] = recent_hashes_shadow[k - 1];
    recent_hashes_shadow[0] = h;
    return r;
  endfunction

  // Sends one request. Outside a quiet phase the sender first idles for a random
  // number of cycles. It holds valid and payload until the transfer, and records
  // the result that the shadow predicts for it.
  task automatic send_request(input logic [31:0] target_v, input logic [31:0] now_v,
                              input logic imm);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    target_ref  <= target_v;
    now_seconds <= now_v;
    immune      <= imm;
    do
      @(posedge clk);
    while (!in_ready);
    expected_results.push_back(apply_request(target_v, now_v, imm));
    requests_sent++;
  endtask

  // Stops sending and waits until every owed result has been taken, then lets
  // the block settle.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes one register while the block is idle: a setup cycle, then an access
  // cycle, at whose closing edge the register takes the new value.
  task automatic program_register(input logic idx, input logic [31:0] word);
    wait_for_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_LIST_LENGTH)
      list_len_cfg = word[5:0];
    else
      interval_cfg = word[15:0];
    settings_written++;
  endtask

  // After reset: the cleared list matches hash zero, immune requests pass,
  // a new target spends credit and the next one at the same time is refused.
  // A request at the top of time makes the next-allowed time catch up.
  task automatic test_reset_state();
    send_request(32'd0, 32'd0, 1'b0);
    send_request(32'h1234_5678, 32'd5, 1'b1);
    send_request(32'hFFFF_FFFF, 32'd0, 1'b0);
    send_request(ref_for_hash(8'd1), 32'd0, 1'b0);
    send_request(ref_for_hash(8'd2), 32'd0, 1'b0);
    send_request(ref_for_hash(8'd1), 32'd0, 1'b0);
    send_request(32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b0);
    send_request(ref_for_hash(8'd3), 32'd0, 1'b0);
  endtask

  // List length one, zero (acts as one) and an oversized value (acts as the full
  // depth). Steps are wide, yet new targets are refused: they stay under next-allowed.
  task automatic test_list_length();
    logic [31:0] t;
    t = 32'd100_000;
    program_register(REG_LIST_LENGTH, 32'd1);
    send_request(ref_for_hash(8'd10), t, 1'b0);
    t += 32'd100_000;
    send_request(ref_for_hash(8'd10), t, 1'b0);
    t += 32'd100_000;
    send_request(ref_for_hash(8'd11), t, 1'b0);
    t += 32'd100_000;
    // Only the front slot is searched, so this target counts as new again.
    send_request(ref_for_hash(8'd10), t, 1'b0);
    t += 32'd100_000;
    program_register(REG_LIST_LENGTH, 32'd0);
    send_request(ref_for_hash(8'd10), t, 1'b0);
    t += 32'd100_000;
    send_request(ref_for_hash(8'd11), t, 1'b0);
    t += 32'd100_000;
    send_request(ref_for_hash(8'd11), t, 1'b0);
    t += 32'd100_000;
    program_register(REG_LIST_LENGTH, 32'd63);
    send_request(ref_for_hash(8'd0), t, 1'b0);
    t += 32'd100_000;
    send_request(ref_for_hash(8'd12), t, 1'b0);
  endtask

  // A zero interval makes new targets free. The largest interval on a one-slot
  // list, reached from the top of time, gives a wait that saturates.
  task automatic test_interval_settings();
    logic [31:0] t;
    t = 32'd5_000_000;
    program_register(REG_LIST_LENGTH, 32'd20);
    program_register(REG_INTERVAL, 32'd0);
    send_request(ref_for_hash(8'd20), t, 1'b0);
    send_request(ref_for_hash(8'd21), t, 1'b0);
    send_request(ref_for_hash(8'd22), t, 1'b0);
    program_register(REG_LIST_LENGTH, 32'd1);
    program_register(REG_INTERVAL, 32'd65535);
    send_request(ref_for_hash(8'd30), 32'hFFFF_FFFF, 1'b0);
    send_request(ref_for_hash(8'd31), 32'd0, 1'b0);
  endtask

  // Random traffic over several register settings. Most requests follow a
  // clock that moves forward and pick targets from a pool a little larger than
  // the list, so hits, misses, refusals and catch-ups all occur. The rest are
  // fresh targets and pure noise with random time and immunity.
  task automatic test_random_traffic();
    int unsigned len_sel [8] = '{20, 1, 32, 0, 63, 5, 0, 32};
    int unsigned ivl_sel [8] = '{15, 1, 65535, 0, 3, 0, 0, 1};
    logic [31:0] pool [64];
    logic [31:0] clock_s;
    logic [31:0] tgt;
    logic [31:0] stamp;
    logic        imm;
    int unsigned eff;
    int unsigned step_max;
    int unsigned span;
    int          pool_n;
    int          roll;
    int          phase;
    int          n;
    int          k;
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 5)
        ivl_sel[5] = $urandom_range(1, 300);
      if (phase == 6) begin
        len_sel[6] = $urandom_range(1, LIST_SLOTS);
        ivl_sel[6] = $urandom_range(1, 2000);
      end
      // Upper data bits are random; the registers keep only their own width.
      program_register(REG_LIST_LENGTH, (32'($urandom) & 32'hFFFF_FFC0) | len_sel[phase]);
      program_register(REG_INTERVAL, (32'($urandom) & 32'hFFFF_0000) | ivl_sel[phase]);
      eff = active_slots();
      pool_n = eff + $urandom_range(1, eff + 2);
      if (pool_n > 64)
        pool_n = 64;
      for (k = 0; k < pool_n; k++)
        pool[k] = $urandom;
      clock_s = $urandom;
      quiet_phase = (phase % 3 == 2);
      step_max = ivl_sel[phase] / 2 + 1;
      span = eff * ivl_sel[phase] * 2 + 16;
      for (n = 0; n < 60; n++) begin
        if ($urandom_range(0, 99) < 8)
          clock_s += $urandom_range(0, span);
        else
          clock_s += $urandom_range(0, step_max);
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          tgt   = pool[$urandom_range(0, pool_n - 1)];
          stamp = clock_s;
          imm   = ($urandom_range(0, 9) == 0);
        end else if (roll < 88) begin
          tgt   = $urandom;
          stamp = clock_s;
          imm   = 1'b0;
        end else begin
          tgt   = $urandom;
          stamp = $urandom;
          imm   = 1'(($urandom_range(0, 1)));
        end
        send_request(tgt, stamp, imm);
      end
    end
    quiet_phase = 1'b0;
  endtask

  // Result side: outside a quiet phase the receiver may drop ready for a random
  // number of cycles after each transfer, which stalls results in the back end.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      ready_hold = quiet_phase ? 0 : $urandom_range(0, 3);
      out_ready <= (ready_hold == 0);
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= (ready_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result transfer is checked field by field against the oldest
  // expectation.
  trl_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_error("result transfer with no request outstanding");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (refused !== want.refused)
          report_error($sformatf("refused: expected %0b, got %0b", want.refused, refused));
        if (wait_seconds !== want.wait_seconds)
          report_error($sformatf("wait_seconds: expected %0h, got %0h",
                                 want.wait_seconds, wait_seconds));
        if (lag_add !== want.lag_add)
          report_error($sformatf("lag_add: expected %0d, got %0d", want.lag_add, lag_add));
        if (was_known !== want.was_known)
          report_error($sformatf("was_known: expected %0b, got %0b",
                                 want.was_known, was_known));
      end
    end
  end

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    target_ref  = 32'd0;
    now_seconds = 32'd0;
    immune      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = 3'd0;
    pwdata      = 32'd0;
    quiet_phase = 1'b0;
    reset_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_list_length();
    test_interval_settings();
    test_random_traffic();

    // Let the last results drain, with a bound of its own.
    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE) @(posedge clk);
    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));

    $display("Sent %0d requests over %0d register writes; %0d results checked.",
             requests_sent, settings_written, results_checked);
    $display("Seen: %0d known, %0d refused, %0d immune, %0d catch-ups; %0d mismatches.",
             known_count, refused_count, immune_count, catchup_count, mismatch_count);
    if (mismatch_count == 0)
      $display("PASS target_rate_limiter_mru_top");
    else
      $display("FAIL target_rate_limiter_mru_top");
    $finish;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #2_000_000;
    $display("FAIL target_rate_limiter_mru_top");
    $finish;
  end

endmodule
